// ----- rtl/tsd_pkg.sv -----
// Shared types, constants and the CRC-8 step for the scratchpad decoder.
// No dependencies; every module of the block imports this package.
package tsd_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0]  LAST_BYTE     = 4'd8;
  localparam logic [3:0]  HIGH_BYTE     = 4'd1;
  localparam logic [3:0]  REMAIN_BYTE   = 4'd6;
  localparam logic [7:0]  CRC_POLY_REFL = 8'h8C;
  localparam logic [15:0] TWELVE_MAX    = 16'd2047;
  localparam logic signed [16:0] HALF_OFFSET = 17'sd4;

  localparam logic [7:0] FAM_HALF_RST  = 8'd16;
  localparam logic [7:0] FAM_TWA_RST   = 8'd34;
  localparam logic [7:0] FAM_TWB_RST   = 8'd40;
  localparam logic [7:0] FAM_THERM_RST = 8'd59;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CRC    = 2'd1,
    ST_FAMILY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_FAM_HALF  = 2'd0,
    REG_FAM_TWA   = 2'd1,
    REG_FAM_TWB   = 2'd2,
    REG_FAM_THERM = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] fam_half;
    logic [7:0] fam_twa;
    logic [7:0] fam_twb;
    logic [7:0] fam_therm;
  } cfg_t;

  // One finished frame, handed from the front end to the decode stage.
  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] remain;
    logic [7:0] family;
    logic       crc_ok;
  } rec_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/tsd_front.sv -----
// Front end: counts scratchpad bytes, runs the CRC and captures bytes 0, 1 and 6.
// Emits one frame record on the ninth byte. Depends on tsd_pkg.
module tsd_front import tsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] family_code_i,
  input  logic       frame_start_i,
  output logic       rec_push_o,
  output rec_t       rec_o
);

  logic [3:0] count_q, count_d, count_cur;
  logic [7:0] crc_q, crc_d, crc_cur;
  logic [7:0] lo_q, lo_d, hi_q, hi_d, remain_q, remain_d, fam_q, fam_d;

  always_comb begin
    count_cur = frame_start_i ? 4'd0 : count_q;
    if (count_cur > LAST_BYTE) begin
      count_cur = 4'd0;
    end
    crc_cur    = frame_start_i ? 8'd0 : crc_q;
    fam_d      = frame_start_i ? family_code_i : fam_q;
    count_d    = count_q;
    crc_d      = crc_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    remain_d   = remain_q;
    rec_push_o = 1'b0;
    if (beat_i) begin
      if (count_cur != LAST_BYTE) begin
        if (count_cur == 4'd0) begin
          lo_d = data_byte_i;
        end
        if (count_cur == HIGH_BYTE) begin
          hi_d = data_byte_i;
        end
        if (count_cur == REMAIN_BYTE) begin
          remain_d = data_byte_i;
        end
        crc_d   = crc8_step(crc_cur, data_byte_i);
        count_d = count_cur + 4'd1;
      end else begin
        crc_d      = crc_cur;
        count_d    = 4'd0;
        rec_push_o = 1'b1;
      end
    end
  end

  assign rec_o = '{lo: lo_q, hi: hi_q, remain: remain_q, family: fam_d,
                   crc_ok: (crc_cur == data_byte_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
      crc_q   <= 8'd0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    remain_q <= remain_d;
    if (beat_i) begin
      fam_q <= fam_d;
    end
  end

endmodule

// ----- rtl/tsd_fifo.sv -----
// Short queue of frame records between the front end and the decode stage.
// Depth comes from tsd_pkg::FIFO_DEPTH.
module tsd_fifo import tsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  rec_t wr_data_i,
  input  logic rd_i,
  output rec_t rd_data_o,
  output logic valid_o,
  output logic full_o
);

  localparam logic [FIFO_PTR_W-1:0] LAST_PTR = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] DEPTH_CNT = FIFO_CNT_W'(FIFO_DEPTH);

  rec_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign valid_o   = (cnt_q != '0);
  assign full_o    = (cnt_q == DEPTH_CNT);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- rtl/tsd_back.sv -----
// Decode stage: classifies the frame by family, converts to sixteenths and
// holds the result in an output register. Depends on tsd_pkg.
module tsd_back import tsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               rec_valid_i,
  input  rec_t               rec_i,
  output logic               rec_pop_o,
  input  logic               out_pop_i,
  output logic               out_valid_o,
  output logic signed [16:0] temp_o,
  output status_e            status_o
);

  logic               out_valid_q, out_valid_d;
  logic signed [16:0] temp_q, temp_d;
  status_e            status_q, status_d;
  logic [15:0]        half_word, raw16, therm_word;
  logic [3:0]         frac;

  assign rec_pop_o = rec_valid_i && (!out_valid_q || out_pop_i);

  always_comb begin
    // Count-remain refinement: (16 - remain) modulo 16.
    frac       = 4'd0 - rec_i.remain[3:0];
    half_word  = {rec_i.hi[4:0], rec_i.lo[7:1], frac};
    raw16      = {rec_i.hi, rec_i.lo};
    therm_word = {rec_i.hi, rec_i.lo[7:2], 2'b00};
    temp_d     = 17'sd0;
    status_d   = ST_OK;
    if (!rec_i.crc_ok) begin
      status_d = ST_CRC;
    end else if (rec_i.family == cfg_i.fam_half) begin
      temp_d = $signed({half_word[15], half_word}) - HALF_OFFSET;
    end else if (rec_i.family == cfg_i.fam_twa || rec_i.family == cfg_i.fam_twb) begin
      // Values above the 12-bit maximum are treated as negative 16-bit words.
      temp_d = $signed({(raw16 > TWELVE_MAX), raw16});
    end else if (rec_i.family == cfg_i.fam_therm) begin
      temp_d = $signed({therm_word[15], therm_word});
    end else begin
      status_d = ST_FAMILY;
    end
    out_valid_d = rec_pop_o || (out_valid_q && !out_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      temp_q   <= temp_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_o      = temp_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/temp_scratchpad_decoder.sv -----
// Scratchpad decoder top level: front end, record queue, decode stage, config.
// Takes one byte per cycle while full is low; each frame record enters the queue
// at the edge that takes its ninth byte, then moves to the output register once free.
// full rises only when the two-entry record queue is full and the output is held.
// Reset clears the byte count, CRC, queue and output valid; family registers return
// to 16, 34, 40 and 59. Depends on tsd_pkg and all tsd_* modules.
module temp_scratchpad_decoder import tsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic [7:0]         family_code_i,
  input  logic               frame_start_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] temperature_sixteenths_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    beat, rec_push, rec_pop, rec_valid, mid_full, out_valid;
  rec_t    rec_in, rec_out;
  status_e status;

  assign cfg_ready_o = 1'b1;
  assign full        = mid_full;
  assign beat        = push && !mid_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_FAM_HALF:  cfg_d.fam_half  = cfg_data_i;
        REG_FAM_TWA:   cfg_d.fam_twa   = cfg_data_i;
        REG_FAM_TWB:   cfg_d.fam_twb   = cfg_data_i;
        REG_FAM_THERM: cfg_d.fam_therm = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fam_half: FAM_HALF_RST, fam_twa: FAM_TWA_RST,
                 fam_twb: FAM_TWB_RST, fam_therm: FAM_THERM_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .beat_i        (beat),
    .data_byte_i   (data_byte_i),
    .family_code_i (family_code_i),
    .frame_start_i (frame_start_i),
    .rec_push_o    (rec_push),
    .rec_o         (rec_in)
  );

  tsd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_push),
    .wr_data_i (rec_in),
    .rd_i      (rec_pop),
    .rd_data_o (rec_out),
    .valid_o   (rec_valid),
    .full_o    (mid_full)
  );

  tsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .temp_o      (temperature_sixteenths_o),
    .status_o    (status)
  );

  assign empty    = !out_valid;
  assign status_o = status;

  a_status_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status != ST_OK) |-> (temperature_sixteenths_o == 17'sd0))
    else $error("nonzero temperature with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status == ST_OK || status == ST_CRC || status == ST_FAMILY))
    else $error("undefined status code on output");

  a_queue_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_full |-> (rec_valid && !empty))
    else $error("record queue full while decode stage is not holding a result");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid && empty) |=> !empty)
    else $error("waiting record was not moved to the output register");

endmodule
